/* sv/llepd_pkg.sv */
// ----------------------------------------------------------------------------
// llepd_pkg
// Types, codes and constants shared by the login line editor modules.
// ----------------------------------------------------------------------------
package llepd_pkg;

  localparam int unsigned NAME_CAP = 32;
  localparam int unsigned IDX_W    = $clog2(NAME_CAP);
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned CHAR_W   = 7;
  localparam int unsigned BYTE_W   = 8;

  // character codes
  localparam logic [CHAR_W-1:0] CH_CTRL_D = 7'd4;
  localparam logic [CHAR_W-1:0] CH_BS     = 7'd8;
  localparam logic [CHAR_W-1:0] CH_NL     = 7'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'd13;
  localparam logic [CHAR_W-1:0] CH_CTRL_U = 7'd21;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'd32;
  localparam logic [CHAR_W-1:0] CH_HASH   = 7'd35;
  localparam logic [CHAR_W-1:0] CH_AT     = 7'd64;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 7'd126;
  localparam logic [CHAR_W-1:0] CH_DEL    = 7'd127;

  typedef enum logic [2:0] {
    KIND_ECHO     = 3'd0,
    KIND_ERASE    = 3'd1,
    KIND_NAME     = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_REPROMPT = 3'd4,
    KIND_HANGUP   = 3'd5,
    KIND_ABORT    = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    CLS_EOL,
    CLS_ERASE,
    CLS_KILL,
    CLS_HANGUP,
    CLS_PRINT,
    CLS_IGNORE
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_NAME,
    ST_DONE,
    ST_KILL
  } state_e;

  typedef struct packed {
    logic  load;
    logic  emit;
    kind_e kind;
    logic  last;
    logic  store_wr;
    logic  cnt_dec;
    logic  learn_erase;
    logic  learn_kill;
    logic  sess_rst;
    logic  idx_inc;
    logic  idx_clr;
  } cmd_t;

  typedef struct packed {
    cls_e cls;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic name_last;
    logic slot_free;
  } sts_t;

endpackage

/* sv/login_line_editor_parity_detect_top.sv */
// ----------------------------------------------------------------------------
// login_line_editor_parity_detect_top
// Login-name line editor with parity detection on received terminal bytes.
// ----------------------------------------------------------------------------
// Sequence: a request is taken in idle and decoded in the decode state, which
//   registers at most one result; a kill walks the kill state and a line end the
//   name and done states, emitting one result per cycle while the output slot
//   is free, name characters read from the name store read port. A new byte is
//   taken only once the sequencer is back in idle.
// Reset: asynchronous, clears the sequencer, session registers and output
//   valid; the name store is not cleared and is only read where written.
module login_line_editor_parity_detect_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [llepd_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [llepd_pkg::BYTE_W-1:0]  data_o,
  output logic [1:0]                    erase_variant_o,
  output logic [llepd_pkg::CHAR_W-1:0]  eol_char_o,
  output logic [llepd_pkg::CHAR_W-1:0]  erase_char_o,
  output logic [llepd_pkg::CHAR_W-1:0]  kill_char_o,
  output logic [1:0]                    parity_seen_o,
  output logic [llepd_pkg::CNT_W-1:0]   name_length_o,
  output logic                          last_o
);

  llepd_pkg::cmd_t cmd;
  llepd_pkg::sts_t sts;

  llepd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  llepd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .data_o          (data_o),
    .erase_variant_o (erase_variant_o),
    .eol_char_o      (eol_char_o),
    .erase_char_o    (erase_char_o),
    .kill_char_o     (kill_char_o),
    .parity_seen_o   (parity_seen_o),
    .name_length_o   (name_length_o),
    .last_o          (last_o)
  );

endmodule

/* sv/llepd_dpath.sv */
// ----------------------------------------------------------------------------
// llepd_dpath
// Session registers, name store, byte classifier and result register.
// ----------------------------------------------------------------------------
module llepd_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  llepd_pkg::cmd_t               cmd_i,
  output llepd_pkg::sts_t               sts_o,
  input  logic [llepd_pkg::BYTE_W-1:0]  rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    kind_o,
  output logic [llepd_pkg::BYTE_W-1:0]  data_o,
  output logic [1:0]                    erase_variant_o,
  output logic [llepd_pkg::CHAR_W-1:0]  eol_char_o,
  output logic [llepd_pkg::CHAR_W-1:0]  erase_char_o,
  output logic [llepd_pkg::CHAR_W-1:0]  kill_char_o,
  output logic [1:0]                    parity_seen_o,
  output logic [llepd_pkg::CNT_W-1:0]   name_length_o,
  output logic                          last_o
);

  logic [llepd_pkg::BYTE_W-1:0] byte_q;
  logic [llepd_pkg::CHAR_W-1:0] chr;
  logic [llepd_pkg::CNT_W-1:0]  count_q, count_d;
  logic [llepd_pkg::CHAR_W-1:0] erase_q, erase_d;
  logic [llepd_pkg::CHAR_W-1:0] kill_q, kill_d;
  logic [1:0]                   parity_q, parity_d;
  logic [llepd_pkg::IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [llepd_pkg::CHAR_W-1:0] rd_data_q;
  logic [llepd_pkg::CHAR_W-1:0] store [llepd_pkg::NAME_CAP];
  logic [1:0]                   parity_new;
  llepd_pkg::cls_e              cls;

  logic                         out_valid_q, out_valid_d;
  llepd_pkg::kind_e             kind_q;
  logic [llepd_pkg::BYTE_W-1:0] data_q, data_d;
  logic [1:0]                   variant_q;
  logic [llepd_pkg::CHAR_W-1:0] eol_q, erase_out_q, kill_out_q;
  logic [1:0]                   parity_out_q;
  logic [llepd_pkg::CNT_W-1:0]  length_q, length_d;
  logic                         last_q;

  assign chr = byte_q[llepd_pkg::CHAR_W-1:0];

  // classify the held byte
  always_comb begin
    unique case (chr) inside
      llepd_pkg::CH_CR, llepd_pkg::CH_NL:                   cls = llepd_pkg::CLS_EOL;
      llepd_pkg::CH_BS, llepd_pkg::CH_DEL, llepd_pkg::CH_HASH: cls = llepd_pkg::CLS_ERASE;
      llepd_pkg::CH_CTRL_U, llepd_pkg::CH_AT:               cls = llepd_pkg::CLS_KILL;
      llepd_pkg::CH_CTRL_D:                                 cls = llepd_pkg::CLS_HANGUP;
      default: begin
        if (chr >= llepd_pkg::CH_SPACE && chr <= llepd_pkg::CH_TILDE) begin
          cls = llepd_pkg::CLS_PRINT;
        end else begin
          cls = llepd_pkg::CLS_IGNORE;
        end
      end
    endcase
  end

  assign sts_o.cls       = cls;
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.cnt_one   = (count_q == llepd_pkg::CNT_W'(1));
  assign sts_o.full      = (count_q >= llepd_pkg::CNT_W'(llepd_pkg::NAME_CAP - 1));
  assign sts_o.name_last = (llepd_pkg::CNT_W'(rd_idx_q) + llepd_pkg::CNT_W'(1) == count_q);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  // parity of incoming byte: one plus the ones in the low 7 bits
  assign parity_new = (^rx_byte_i[llepd_pkg::CHAR_W-1:0]) ? 2'b10 : 2'b01;

  always_comb begin
    count_d  = count_q;
    erase_d  = erase_q;
    kill_d   = kill_q;
    parity_d = parity_q;
    rd_idx_d = rd_idx_q;
    if (cmd_i.load && rx_byte_i[llepd_pkg::BYTE_W-1]) begin
      parity_d = parity_q | parity_new;
    end
    if (cmd_i.learn_erase) begin
      erase_d = chr;
    end
    if (cmd_i.learn_kill) begin
      kill_d = chr;
    end
    if (cmd_i.store_wr) begin
      count_d = count_q + llepd_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - llepd_pkg::CNT_W'(1);
    end
    if (cmd_i.sess_rst) begin
      count_d  = '0;
      erase_d  = llepd_pkg::CH_DEL;
      kill_d   = llepd_pkg::CH_CTRL_U;
      parity_d = '0;
    end
    if (cmd_i.idx_clr) begin
      rd_idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      rd_idx_d = rd_idx_q + llepd_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      erase_q  <= llepd_pkg::CH_DEL;
      kill_q   <= llepd_pkg::CH_CTRL_U;
      parity_q <= '0;
      rd_idx_q <= '0;
    end else begin
      count_q  <= count_d;
      erase_q  <= erase_d;
      kill_q   <= kill_d;
      parity_q <= parity_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= rx_byte_i;
    end
  end

  // name store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store[count_q[llepd_pkg::IDX_W-1:0]] <= chr;
    end
    rd_data_q <= store[rd_idx_d];
  end

  // result register
  always_comb begin
    case (cmd_i.kind)
      llepd_pkg::KIND_ECHO: data_d = byte_q;
      llepd_pkg::KIND_NAME: data_d = {1'b0, rd_data_q};
      default:              data_d = '0;
    endcase
    if (cmd_i.store_wr) begin
      length_d = count_q + llepd_pkg::CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      length_d = count_q - llepd_pkg::CNT_W'(1);
    end else begin
      length_d = count_q;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q       <= cmd_i.kind;
      data_q       <= data_d;
      variant_q    <= (cmd_i.kind == llepd_pkg::KIND_ERASE) ? parity_q : 2'b00;
      eol_q        <= (cmd_i.kind == llepd_pkg::KIND_DONE) ? chr : '0;
      erase_out_q  <= cmd_i.learn_erase ? chr : erase_q;
      kill_out_q   <= kill_q;
      parity_out_q <= parity_q;
      length_q     <= length_d;
      last_q       <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign data_o          = data_q;
  assign erase_variant_o = variant_q;
  assign eol_char_o      = eol_q;
  assign erase_char_o    = erase_out_q;
  assign kill_char_o     = kill_out_q;
  assign parity_seen_o   = parity_out_q;
  assign name_length_o   = length_q;
  assign last_o          = last_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= llepd_pkg::CNT_W'(llepd_pkg::NAME_CAP - 1))
    else $error("name count beyond store capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit && out_valid_q && !out_ready_i))
    else $error("result register overwritten while stalled");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_inc |-> (llepd_pkg::CNT_W'(rd_idx_q) < count_q))
    else $error("name readout past stored length");

  a_sess_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sess_rst |=> (count_q == '0 && parity_q == '0))
    else $error("session not cleared");
`endif

endmodule

/* sv/llepd_ctrl.sv */
// ----------------------------------------------------------------------------
// llepd_ctrl
// Sequencer: takes a request, dispatches it, walks name readout and kill.
// ----------------------------------------------------------------------------
module llepd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  llepd_pkg::sts_t sts_i,
  output llepd_pkg::cmd_t cmd_o
);

  llepd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= llepd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      llepd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = llepd_pkg::ST_DECODE;
        end
      end
      llepd_pkg::ST_DECODE: begin
        case (sts_i.cls)
          llepd_pkg::CLS_EOL: begin
            if (!sts_i.cnt_zero) begin
              state_d = llepd_pkg::ST_NAME;
            end else if (sts_i.slot_free) begin
              state_d = llepd_pkg::ST_IDLE;
            end
          end
          llepd_pkg::CLS_ERASE, llepd_pkg::CLS_HANGUP, llepd_pkg::CLS_PRINT: begin
            if (sts_i.slot_free || (sts_i.cls == llepd_pkg::CLS_ERASE && sts_i.cnt_zero)) begin
              state_d = llepd_pkg::ST_IDLE;
            end
          end
          llepd_pkg::CLS_KILL: begin
            state_d = sts_i.cnt_zero ? llepd_pkg::ST_IDLE : llepd_pkg::ST_KILL;
          end
          default: state_d = llepd_pkg::ST_IDLE;
        endcase
      end
      llepd_pkg::ST_NAME: begin
        if (sts_i.slot_free && sts_i.name_last) begin
          state_d = llepd_pkg::ST_DONE;
        end
      end
      llepd_pkg::ST_DONE: begin
        if (sts_i.slot_free) begin
          state_d = llepd_pkg::ST_IDLE;
        end
      end
      llepd_pkg::ST_KILL: begin
        if (sts_i.slot_free && sts_i.cnt_one) begin
          state_d = llepd_pkg::ST_IDLE;
        end
      end
      default: state_d = llepd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = llepd_pkg::KIND_ECHO;
    in_ready_o = 1'b0;
    unique case (state_q)
      llepd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      llepd_pkg::ST_DECODE: begin
        case (sts_i.cls)
          llepd_pkg::CLS_EOL: begin
            if (sts_i.cnt_zero && sts_i.slot_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = llepd_pkg::KIND_REPROMPT;
              cmd_o.last = 1'b1;
            end
          end
          llepd_pkg::CLS_ERASE: begin
            if (sts_i.cnt_zero) begin
              cmd_o.learn_erase = 1'b1;
            end else if (sts_i.slot_free) begin
              cmd_o.learn_erase = 1'b1;
              cmd_o.cnt_dec     = 1'b1;
              cmd_o.emit        = 1'b1;
              cmd_o.kind        = llepd_pkg::KIND_ERASE;
              cmd_o.last        = 1'b1;
            end
          end
          llepd_pkg::CLS_KILL: begin
            cmd_o.learn_kill = 1'b1;
          end
          llepd_pkg::CLS_HANGUP: begin
            if (sts_i.slot_free) begin
              cmd_o.emit     = 1'b1;
              cmd_o.kind     = llepd_pkg::KIND_HANGUP;
              cmd_o.last     = 1'b1;
              cmd_o.sess_rst = 1'b1;
            end
          end
          llepd_pkg::CLS_PRINT: begin
            if (sts_i.slot_free) begin
              cmd_o.emit = 1'b1;
              cmd_o.last = 1'b1;
              if (sts_i.full) begin
                cmd_o.kind     = llepd_pkg::KIND_ABORT;
                cmd_o.sess_rst = 1'b1;
              end else begin
                cmd_o.kind     = llepd_pkg::KIND_ECHO;
                cmd_o.store_wr = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      llepd_pkg::ST_NAME: begin
        if (sts_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = llepd_pkg::KIND_NAME;
          cmd_o.idx_inc = 1'b1;
        end
      end
      llepd_pkg::ST_DONE: begin
        if (sts_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.kind     = llepd_pkg::KIND_DONE;
          cmd_o.last     = 1'b1;
          cmd_o.sess_rst = 1'b1;
          cmd_o.idx_clr  = 1'b1;
        end
      end
      llepd_pkg::ST_KILL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = llepd_pkg::KIND_ERASE;
          cmd_o.cnt_dec = 1'b1;
          cmd_o.last    = sts_i.cnt_one;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == llepd_pkg::ST_DECODE))
    else $error("accepted request not decoded");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !cmd_o.emit)
    else $error("result issued while taking a request");

  a_kill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == llepd_pkg::ST_KILL) |-> !sts_i.cnt_zero)
    else $error("kill walk on empty name");
`endif

endmodule
